// File: src/rde_pkg.sv
`default_nettype none
package rde_pkg;
    localparam logic [2:0] KIND_INT     = 3'd0;
    localparam logic [2:0] KIND_PRE     = 3'd1;
    localparam logic [2:0] KIND_CYCLE   = 3'd2;
    localparam logic [2:0] KIND_SUMMARY = 3'd3;
    localparam logic [2:0] KIND_ERROR   = 3'd4;
    localparam int NUM_IN_WIDTH = 16;
    localparam int DEN_WIDTH    = 12;
    localparam int VALUE_WIDTH  = 16;
    localparam int DIGIT_WIDTH  = 4;
    localparam int MAX_DENOMINATOR = 4096;
endpackage
`default_nettype wire

// File: src/repeating_decimal_expander_core.sv
// channel | dir | tdata (low bit up)                     | tuser | tlast
// s_axis  | in  | numerator[15:0], denominator[27:16]    | -     | -
// m_axis  | out | value[15:0], truncated[16]             | kind  | last
// a fraction with a valid denominator takes NW steps of restoring division for
// the integer part, then long-division steps (table read, then check and write),
// at most den+1 steps, then emits its results (up to 52); a stalled result
// holds the block. a zero denominator skips to a single error result.
// after reset and after each fraction the seen table is swept, one entry a
// cycle, over all MAX_DENOMINATOR (4096) entries, and no request is taken meanwhile.
`default_nettype none
module repeating_decimal_expander_core #(
    parameter int SHOWN_DIGITS    = 50
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [31:0] s_axis_tdata,   // numerator[15:0], denominator[27:16]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,   // value[15:0], truncated[16]
    output logic [2:0]  m_axis_tuser,   // kind[2:0]
    output logic        m_axis_tlast
);
    localparam int AW = $clog2(rde_pkg::MAX_DENOMINATOR);
    localparam int PW = AW + 1;
    localparam int SW = $clog2(SHOWN_DIGITS + 1);
    localparam int DW = (SHOWN_DIGITS > 1) ? $clog2(SHOWN_DIGITS) : 1;
    localparam int NW = rde_pkg::NUM_IN_WIDTH;
    localparam int CW = $clog2(NW + 1);
    localparam int RW = 13;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_CHECK = 3'd4;
    localparam logic [2:0] S_FIN   = 3'd5;
    localparam logic [2:0] S_EMIT  = 3'd6;

    logic [2:0]  r_state, n_state;
    logic [AW:0] r_clr, n_clr;
    logic [11:0] r_den;
    logic [NW-1:0] r_quo, n_quo;
    logic [RW-1:0] r_rem, n_rem;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [PW-1:0] r_pos, n_pos;
    logic [PW-1:0] r_start, n_start;
    logic [SW:0]   r_idx, n_idx;
    logic          r_err;

    logic          seen_mem [rde_pkg::MAX_DENOMINATOR];
    logic [PW-1:0] pos_mem  [rde_pkg::MAX_DENOMINATOR];
    logic [3:0]    dig_mem  [SHOWN_DIGITS];
    logic          r_seen_q;
    logic [PW-1:0] r_pos_q;
    logic [3:0]    r_dig_q;

    // output register, loaded in the cycle after the digit read is issued
    logic r_ld;
    logic [SW:0] r_oidx;

    logic [11:0] den_in;
    logic [RW+3:0] scaled, sub0;
    logic [3:0] digit;
    logic [RW-1:0] newrem;
    logic [RW:0] trial;
    logic seen_we, seen_wd;
    logic [AW-1:0] seen_wa;
    logic [PW-1:0] shown;
    logic m_fire;
    logic issue;
    logic [DW-1:0] dig_ra;

    assign den_in = s_axis_tdata[27:16];
    assign s_axis_tready = (r_state == S_IDLE) && !m_axis_tvalid;
    assign m_fire = m_axis_tvalid && m_axis_tready;
    assign shown = (r_pos < PW'(SHOWN_DIGITS)) ? r_pos : PW'(SHOWN_DIGITS);
    assign issue = (r_state == S_EMIT) && (!m_axis_tvalid || m_fire) && !r_ld;
    assign dig_ra = (r_idx != '0 && r_idx <= (SW+1)'(SHOWN_DIGITS)) ?
                    DW'(r_idx - 1'b1) : '0;

    always_comb begin
        digit  = 4'd0;
        sub0   = {4'd0, r_rem};
        scaled = sub0 * (RW+4)'(10);
        for (int k = 9; k >= 1; k--) begin
            if (digit == 4'd0 && scaled >= (RW+4)'(r_den) * (RW+4)'(k)) begin
                digit = 4'(k);
            end
        end
        newrem = RW'(scaled - (RW+4)'(r_den) * (RW+4)'(digit));
        trial  = {r_rem, r_quo[NW-1]};
    end

    always_comb begin
        n_state = r_state;
        n_clr = r_clr; n_quo = r_quo; n_rem = r_rem; n_cnt = r_cnt;
        n_pos = r_pos; n_start = r_start; n_idx = r_idx;
        seen_we = 1'b0; seen_wd = 1'b0; seen_wa = r_clr[AW-1:0];
        case (r_state)
            S_CLEAR: begin
                seen_we = 1'b1;
                n_clr = r_clr + 1'b1;
                if (r_clr == (AW+1)'(rde_pkg::MAX_DENOMINATOR - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (s_axis_tvalid && s_axis_tready) begin
                    n_quo = s_axis_tdata[NW-1:0];
                    n_rem = '0; n_cnt = '0; n_pos = '0; n_idx = '0;
                    if (den_in == 12'd0 || 32'(den_in) >= 32'(rde_pkg::MAX_DENOMINATOR))
                        n_state = S_EMIT;
                    else
                        n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (trial >= (RW+1)'(r_den)) begin
                    n_rem = RW'(trial - (RW+1)'(r_den));
                    n_quo = {r_quo[NW-2:0], 1'b1};
                end else begin
                    n_rem = RW'(trial);
                    n_quo = {r_quo[NW-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CW'(NW - 1)) n_state = S_READ;
            end
            S_READ: n_state = S_CHECK;
            S_CHECK: begin
                if (r_seen_q) begin
                    n_start = r_pos_q;
                    n_state = S_FIN;
                end else begin
                    seen_we = 1'b1; seen_wd = 1'b1; seen_wa = r_rem[AW-1:0];
                    n_rem = newrem;
                    n_pos = r_pos + 1'b1;
                    n_state = S_READ;
                end
            end
            S_FIN: n_state = S_EMIT;
            S_EMIT: begin
                if (issue) begin
                    n_idx = r_idx + 1'b1;
                    if (r_err || r_idx == (SW+1)'(shown) + 1'b1) begin
                        n_state = S_CLEAR;
                        n_clr = '0;
                    end
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr <= '0;
            r_err <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr <= n_clr;
            if (r_state == S_IDLE && s_axis_tvalid && s_axis_tready)
                r_err <= (den_in == 12'd0 ||
                          32'(den_in) >= 32'(rde_pkg::MAX_DENOMINATOR));
        end
        r_quo <= n_quo; r_rem <= n_rem; r_cnt <= n_cnt;
        r_pos <= n_pos; r_start <= n_start; r_idx <= n_idx;
        if (r_state == S_IDLE && s_axis_tvalid && s_axis_tready) r_den <= den_in;
    end

    always_ff @(posedge i_clk) begin
        if (seen_we) seen_mem[seen_wa] <= seen_wd;
        if (seen_we && seen_wd) pos_mem[seen_wa] <= r_pos;
        r_seen_q <= seen_mem[r_rem[AW-1:0]];
        r_pos_q  <= pos_mem[r_rem[AW-1:0]];
        if (r_state == S_CHECK && !r_seen_q && r_pos < PW'(SHOWN_DIGITS))
            dig_mem[r_pos[DW-1:0]] <= digit;
        r_dig_q <= dig_mem[dig_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
            r_ld <= 1'b0;
        end else begin
            r_ld <= issue;
            if (r_ld) m_axis_tvalid <= 1'b1;
            else if (m_fire) m_axis_tvalid <= 1'b0;
        end
        if (issue) r_oidx <= r_idx;
        if (r_ld) begin
            if (r_err) begin
                m_axis_tuser <= rde_pkg::KIND_ERROR;
                m_axis_tdata <= '0;
                m_axis_tlast <= 1'b1;
            end else if (r_oidx == '0) begin
                m_axis_tuser <= rde_pkg::KIND_INT;
                m_axis_tdata <= {8'd0,
                                 (32'(r_quo) > 32'hFFFF) ? 16'hFFFF : 16'(r_quo)};
                m_axis_tlast <= 1'b0;
            end else if (r_oidx == (SW+1)'(shown) + 1'b1) begin
                m_axis_tuser <= rde_pkg::KIND_SUMMARY;
                m_axis_tdata <= {7'd0, r_pos > PW'(SHOWN_DIGITS), 16'(r_pos - r_start)};
                m_axis_tlast <= 1'b1;
            end else begin
                m_axis_tuser <= (32'(r_oidx) - 1 < 32'(r_start)) ?
                                rde_pkg::KIND_PRE : rde_pkg::KIND_CYCLE;
                m_axis_tdata <= {20'd0, r_dig_q};
                m_axis_tlast <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

// File: src/rde_checker.sv
`default_nettype none
module rde_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [23:0] m_axis_tdata,
    input wire [2:0]  m_axis_tuser,
    input wire        m_axis_tlast
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output dropped while stalled");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser <= rde_pkg::KIND_ERROR)
        else $error("bad kind");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tlast == (m_axis_tuser == rde_pkg::KIND_SUMMARY ||
                                           m_axis_tuser == rde_pkg::KIND_ERROR))
        else $error("last mismatch");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken while busy");
endmodule
bind repeating_decimal_expander_core rde_checker u_chk (.*);
`default_nettype wire
